// File: hw/rtl/camera_feature_frame_parser_defines.svh
// Assertion macros used by the frame parser's parse module.
`ifndef CAMERA_FEATURE_FRAME_PARSER_DEFINES_SVH
`define CAMERA_FEATURE_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CFFP_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("frame parser check failed");

// Next-cycle implication, checked outside reset.
`define CFFP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("frame parser check failed");

`endif

// File: hw/rtl/cffp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cffp_pkg;

    localparam logic [7:0] HEADER_BYTE  = 8'hAA;
    localparam logic [7:0] TAIL_BYTE    = 8'hFF;
    localparam logic [7:0] KIND_BYTE_NOTHING = 8'h29;
    localparam logic [7:0] KIND_BYTE_DOT     = 8'h30;
    localparam logic [7:0] KIND_BYTE_LINE    = 8'h31;
    localparam logic [7:0] KIND_BYTE_CIRCLE  = 8'h32;

    localparam logic [2:0] POS_HUNT  = 3'd0;
    localparam logic [2:0] POS_KIND  = 3'd1;
    localparam logic [2:0] POS_FIRST = 3'd2;
    localparam logic [2:0] POS_LAST  = 3'd6;
    localparam logic [2:0] POS_TAIL  = 3'd7;

    localparam int PAYLOAD_LEN = 5;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_NOTHING = 3'd1,
        KIND_DOT     = 3'd2,
        KIND_LINE    = 3'd3,
        KIND_CIRCLE  = 3'd4
    } kind_t;

    typedef struct packed {
        logic [1:0]  frame_kind;
        logic [7:0]  found_flag;
        logic [15:0] first_value;
        logic [15:0] second_value;
    } result_t;

    function automatic kind_t kind_decode(input logic [7:0] b);
        kind_t k;
        unique case (b)
            KIND_BYTE_NOTHING: k = KIND_NOTHING;
            KIND_BYTE_DOT:     k = KIND_DOT;
            KIND_BYTE_LINE:    k = KIND_LINE;
            KIND_BYTE_CIRCLE:  k = KIND_CIRCLE;
            default:           k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cffp_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module cffp_in_stage (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_byte_in,
    input  wire logic       take,
    output logic            byte_valid,
    output logic [7:0]      byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_byte_in;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

`default_nettype wire

// File: hw/rtl/cffp_parse.sv
`timescale 1ns / 1ps
`default_nettype none
`include "camera_feature_frame_parser_defines.svh"

module cffp_parse
    import cffp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       take,
    input  wire logic [7:0] byte_data,
    output logic            emit,
    output result_t         result
);

    logic [2:0] pos_reg;
    logic [2:0] pos_next;
    kind_t      held_reg;
    kind_t      held_next;
    kind_t      kind_in;
    logic [7:0] store_reg [PAYLOAD_LEN];
    logic [2:0] store_idx;
    logic       in_payload;
    logic       kind_emits;

    assign kind_in    = kind_decode(byte_data);
    assign in_payload = (pos_reg >= POS_FIRST) && (pos_reg <= POS_LAST);
    assign store_idx  = pos_reg - POS_FIRST;
    assign kind_emits = (held_reg == KIND_DOT) || (held_reg == KIND_LINE)
                     || (held_reg == KIND_CIRCLE);

    always_comb begin
        pos_next  = pos_reg;
        held_next = held_reg;
        emit      = 1'b0;
        if (take) begin
            priority if (pos_reg == POS_HUNT) begin
                if (byte_data == HEADER_BYTE) begin
                    pos_next = POS_KIND;
                end
            end else if (pos_reg == POS_KIND) begin
                held_next = kind_in;
                pos_next  = (kind_in == KIND_NONE) ? POS_HUNT : POS_FIRST;
            end else if (pos_reg == POS_TAIL) begin
                pos_next  = POS_HUNT;
                held_next = KIND_NONE;
                emit      = (byte_data == TAIL_BYTE) && kind_emits;
            end else begin
                pos_next = pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= POS_HUNT;
            held_reg <= KIND_NONE;
        end else begin
            pos_reg  <= pos_next;
            held_reg <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && in_payload) begin
            store_reg[store_idx] <= byte_data;
        end
    end

    assign result.frame_kind   = 2'(3'(held_reg) - 3'(KIND_DOT));
    assign result.found_flag   = store_reg[0];
    assign result.first_value  = {store_reg[1], store_reg[2]};
    assign result.second_value = {store_reg[3], store_reg[4]};

    `CFFP_ASSERT_SAME(a_emit_at_tail, aclk, aresetn, emit, pos_reg == POS_TAIL && take)
    `CFFP_ASSERT_SAME(a_kind_held_in_frame, aclk, aresetn, pos_reg >= POS_FIRST, held_reg != KIND_NONE)
    `CFFP_ASSERT_NEXT(a_tail_restarts, aclk, aresetn, take && pos_reg == POS_TAIL, pos_reg == POS_HUNT && held_reg == KIND_NONE)

endmodule

`default_nettype wire

// File: hw/rtl/cffp_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module cffp_out_stage
    import cffp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         take,
    input  wire logic         emit,
    input  wire result_t      result,
    output logic              can_accept,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [1:0]        m_frame_kind,
    output logic [7:0]        m_found_flag,
    output logic signed [15:0] m_first_value,
    output logic signed [15:0] m_second_value
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_accept = !valid_reg || m_ready;
    assign valid_next = can_accept ? (take && emit) : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_accept && take && emit) begin
            result_reg <= result;
        end
    end

    assign m_valid        = valid_reg;
    assign m_frame_kind   = result_reg.frame_kind;
    assign m_found_flag   = result_reg.found_flag;
    assign m_first_value  = $signed(result_reg.first_value);
    assign m_second_value = $signed(result_reg.second_value);

endmodule

`default_nettype wire

// File: hw/rtl/camera_feature_frame_parser.sv
// Result path: a tail byte's result is registered in the output stage as the tail is taken; m_valid comes from it.
// Throughput: one byte per cycle; no byte is taken while a result waits and m_ready is low.
// Backpressure on m_ready stalls the input register, then s_ready, combinationally.
// Reset: synchronous on aresetn low; clears both valid flags, frame position and kind.
// Payload bytes are not reset; every one is written before a result reads it.
`timescale 1ns / 1ps
`default_nettype none

module camera_feature_frame_parser
    import cffp_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_byte_in,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [1:0]         m_frame_kind,
    output logic [7:0]         m_found_flag,
    output logic signed [15:0] m_first_value,
    output logic signed [15:0] m_second_value
);

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       can_accept;
    logic       take;
    logic       emit;
    result_t    result;

    assign take = byte_valid && can_accept;

    cffp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_byte_in  (s_byte_in),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    cffp_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .byte_data (byte_data),
        .emit      (emit),
        .result    (result)
    );

    cffp_out_stage u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .take           (take),
        .emit           (emit),
        .result         (result),
        .can_accept     (can_accept),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_kind   (m_frame_kind),
        .m_found_flag   (m_found_flag),
        .m_first_value  (m_first_value),
        .m_second_value (m_second_value)
    );

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import cffp_pkg::*;

    localparam int BYTE_TARGET     = 1540;
    localparam int STALL_LIMIT     = 1000;
    localparam int REPORT_LIMIT    = 10;
    localparam int DRAIN_CYCLES    = 10;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AFTER  = 40;

    class feature_scoreboard;
        result_t    expected_features[$];
        logic [2:0] position;
        kind_t      held_kind;
        logic [7:0] payload [PAYLOAD_LEN];
        int         errors;
        int         features_seen;
        int         kind_hits [3];
        int         dropped_frames;
        int         silent_frames;

        function new();
            position       = POS_HUNT;
            held_kind      = KIND_NONE;
            errors         = 0;
            features_seen  = 0;
            dropped_frames = 0;
            silent_frames  = 0;
            foreach (kind_hits[i]) kind_hits[i] = 0;
            foreach (payload[i]) payload[i] = 8'h00;
        endfunction

        function kind_t classify(logic [7:0] b);
            case (b)
                KIND_BYTE_NOTHING: return KIND_NOTHING;
                KIND_BYTE_DOT:     return KIND_DOT;
                KIND_BYTE_LINE:    return KIND_LINE;
                KIND_BYTE_CIRCLE:  return KIND_CIRCLE;
                default:           return KIND_NONE;
            endcase
        endfunction

        function void take_byte(logic [7:0] b);
            result_t r;
            case (position)
                POS_HUNT: begin
                    if (b == HEADER_BYTE) position = POS_KIND;
                end
                POS_KIND: begin
                    held_kind = classify(b);
                    if (held_kind == KIND_NONE) begin
                        position = POS_HUNT;
                        dropped_frames++;
                    end else begin
                        position = POS_FIRST;
                    end
                end
                POS_TAIL: begin
                    if (b != TAIL_BYTE) begin
                        dropped_frames++;
                    end else if (held_kind == KIND_NOTHING) begin
                        silent_frames++;
                    end else if (held_kind == KIND_DOT || held_kind == KIND_LINE ||
                                 held_kind == KIND_CIRCLE) begin
                        r.frame_kind   = 2'(held_kind - KIND_DOT);
                        r.found_flag   = payload[0];
                        r.first_value  = {payload[1], payload[2]};
                        r.second_value = {payload[3], payload[4]};
                        expected_features.push_back(r);
                        kind_hits[r.frame_kind]++;
                    end
                    position  = POS_HUNT;
                    held_kind = KIND_NONE;
                end
                default: begin
                    payload[position - POS_FIRST] = b;
                    position = position + 3'd1;
                end
            endcase
        endfunction

        function void report_error(string msg);
            errors++;
            if (errors <= REPORT_LIMIT) $display("MISMATCH %s", msg);
        endfunction

        function void check_feature(logic [1:0] kind, logic [7:0] flag,
                                    logic [15:0] first, logic [15:0] second);
            result_t want;
            if (expected_features.size() == 0) begin
                report_error($sformatf("unexpected result kind=%0d flag=%02h first=%04h second=%04h",
                                       kind, flag, first, second));
                return;
            end
            want = expected_features.pop_front();
            features_seen++;
            if (want.frame_kind !== kind || want.found_flag !== flag ||
                want.first_value !== first || want.second_value !== second) begin
                report_error($sformatf({"result %0d: expected kind=%0d flag=%02h first=%04h ",
                                        "second=%04h, got kind=%0d flag=%02h first=%04h second=%04h"},
                                       features_seen, want.frame_kind, want.found_flag,
                                       want.first_value, want.second_value,
                                       kind, flag, first, second));
            end
        endfunction
    endclass

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [7:0]         s_byte_in = 8'h00;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [1:0]         m_frame_kind;
    logic [7:0]         m_found_flag;
    logic signed [15:0] m_first_value;
    logic signed [15:0] m_second_value;

    feature_scoreboard feature_book = new();
    int  bytes_sent  = 0;
    int  idle_cycles = 0;
    bit  send_burst  = 1'b0;
    bit  recv_burst  = 1'b0;
    bit  held_off    = 1'b0;

    camera_feature_frame_parser u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_byte_in      (s_byte_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_kind   (m_frame_kind),
        .m_found_flag   (m_found_flag),
        .m_first_value  (m_first_value),
        .m_second_value (m_second_value)
    );

    always #1 aclk = ~aclk;

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_byte_in <= b;
        do @(posedge aclk); while (!s_ready);
        feature_book.take_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] kind_byte, input logic [7:0] flag,
                              input logic [15:0] first, input logic [15:0] second,
                              input logic [7:0] tail);
        send_byte(HEADER_BYTE);
        send_byte(kind_byte);
        send_byte(flag);
        send_byte(first[15:8]);
        send_byte(first[7:0]);
        send_byte(second[15:8]);
        send_byte(second[7:0]);
        send_byte(tail);
    endtask

    function automatic logic [7:0] random_kind_byte();
        case ($urandom_range(0, 3))
            0:       return KIND_BYTE_NOTHING;
            1:       return KIND_BYTE_DOT;
            2:       return KIND_BYTE_LINE;
            default: return KIND_BYTE_CIRCLE;
        endcase
    endfunction

    function automatic logic [7:0] random_bad_kind();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == KIND_BYTE_NOTHING || b == KIND_BYTE_DOT ||
               b == KIND_BYTE_LINE || b == KIND_BYTE_CIRCLE);
        return b;
    endfunction

    function automatic logic [7:0] random_bad_tail();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == TAIL_BYTE);
        return b;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            feature_book.check_feature(m_frame_kind, m_found_flag, m_first_value, m_second_value);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin : receiver
        int gap;
        repeat (7) @(posedge aclk);
        forever begin
            if (!held_off && feature_book.features_seen >= HOLD_OFF_AFTER) begin
                // hold off long enough for the parser to back up onto its input
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
                gap = recv_burst ? 0 : $urandom_range(0, 8);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin : sender
        int pick;
        int cut;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_frame(KIND_BYTE_DOT, 8'hFF, 16'h8000, 16'h7FFF, TAIL_BYTE);
        send_frame(KIND_BYTE_CIRCLE, 8'h00, 16'h7FFF, 16'h8000, TAIL_BYTE);
        send_frame(KIND_BYTE_NOTHING, 8'h5A, 16'h1234, 16'hFFFF, TAIL_BYTE);
        // second header byte is a bad kind and sends the parser back to the hunt, not into a new frame
        send_byte(HEADER_BYTE);
        send_byte(HEADER_BYTE);
        send_frame(KIND_BYTE_LINE, 8'h01, 16'h0000, 16'hA5C3, 8'hFE);

        while (bytes_sent < BYTE_TARGET) begin
            if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                send_frame(random_kind_byte(), 8'($urandom_range(0, 255)),
                           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           ($urandom_range(0, 9) == 0) ? random_bad_tail() : TAIL_BYTE);
            end else if (pick < 82) begin
                send_byte(HEADER_BYTE);
                send_byte(random_bad_kind());
            end else if (pick < 90) begin
                // cut a frame after one to six bytes past its kind; below six, the next bytes land mid-frame
                cut = $urandom_range(1, 6);
                send_byte(HEADER_BYTE);
                send_byte(random_kind_byte());
                repeat (cut) send_byte(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end
        end
        s_valid <= 1'b0;

        while (feature_book.expected_features.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb: %0d bytes sent, %0d features checked (dot %0d, line %0d, circle %0d)",
                 bytes_sent, feature_book.features_seen, feature_book.kind_hits[0],
                 feature_book.kind_hits[1], feature_book.kind_hits[2]);
        $display("tb: %0d frames dropped, %0d silent frames, %0d mismatches",
                 feature_book.dropped_frames, feature_book.silent_frames, feature_book.errors);
        if (feature_book.errors == 0 && feature_book.expected_features.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
